FILE: design/jsv_pkg.sv
//------------------------------------------------------------------------------
// jsv_pkg
// Shared constants for the streaming JSON syntax validator.
//------------------------------------------------------------------------------
package jsv_pkg;

  localparam int StackDepth = 512;
  localparam int StackAw    = 9;
  localparam int OffsetBits = 32;

  // parser states
  localparam logic [4:0] S_VALUE     = 5'd0;
  localparam logic [4:0] S_ARR_FIRST = 5'd1;
  localparam logic [4:0] S_ARR_ELEM  = 5'd2;
  localparam logic [4:0] S_OBJ_FIRST = 5'd3;
  localparam logic [4:0] S_OBJ_KEY   = 5'd4;
  localparam logic [4:0] S_COLON     = 5'd5;
  localparam logic [4:0] S_OBJ_NEXT  = 5'd6;
  localparam logic [4:0] S_ARR_NEXT  = 5'd7;
  localparam logic [4:0] S_DONE      = 5'd8;
  localparam logic [4:0] S_STR       = 5'd9;
  localparam logic [4:0] S_ESC       = 5'd10;
  localparam logic [4:0] S_HEX       = 5'd11;
  localparam logic [4:0] S_HIGH_BSL  = 5'd12;
  localparam logic [4:0] S_HIGH_U    = 5'd13;
  localparam logic [4:0] S_LOW_HEX   = 5'd14;
  localparam logic [4:0] S_U8_FIRST  = 5'd15;
  localparam logic [4:0] S_U8_REST   = 5'd16;
  localparam logic [4:0] S_LIT       = 5'd17;
  localparam logic [4:0] S_NUM_SIGN  = 5'd18;
  localparam logic [4:0] S_NUM_ZERO  = 5'd19;
  localparam logic [4:0] S_NUM_INT   = 5'd20;
  localparam logic [4:0] S_NUM_DOT   = 5'd21;
  localparam logic [4:0] S_NUM_FRAC  = 5'd22;
  localparam logic [4:0] S_NUM_E     = 5'd23;
  localparam logic [4:0] S_NUM_ESIGN = 5'd24;
  localparam logic [4:0] S_NUM_EXP   = 5'd25;

  // error codes
  localparam logic [4:0] E_NONE      = 5'd0;
  localparam logic [4:0] E_TRAIL     = 5'd1;
  localparam logic [4:0] E_END       = 5'd2;
  localparam logic [4:0] E_CHAR      = 5'd3;
  localparam logic [4:0] E_DEPTH     = 5'd4;
  localparam logic [4:0] E_KEY       = 5'd5;
  localparam logic [4:0] E_COLON     = 5'd6;
  localparam logic [4:0] E_SEP       = 5'd7;
  localparam logic [4:0] E_COMMA     = 5'd8;
  localparam logic [4:0] E_CTRL      = 5'd9;
  localparam logic [4:0] E_ESC       = 5'd10;
  localparam logic [4:0] E_HEX       = 5'd11;
  localparam logic [4:0] E_HIGH      = 5'd12;
  localparam logic [4:0] E_LOW       = 5'd13;
  localparam logic [4:0] E_LONE_LOW  = 5'd14;
  localparam logic [4:0] E_U8_LEAD   = 5'd15;
  localparam logic [4:0] E_U8_SECOND = 5'd16;
  localparam logic [4:0] E_U8_CONT   = 5'd17;
  localparam logic [4:0] E_MINUS     = 5'd18;
  localparam logic [4:0] E_LZERO     = 5'd19;
  localparam logic [4:0] E_FRAC      = 5'd20;
  localparam logic [4:0] E_EXP       = 5'd21;
  localparam logic [4:0] E_LIT       = 5'd22;
  localparam logic [4:0] E_RANGE     = 5'd23;
  localparam logic [4:0] E_RANGE_U   = 5'd24;
  localparam logic [4:0] E_END_STR   = 5'd25;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // expected literal character by kind and position
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    unique case (w)
      LIT_TRUE: begin
        unique case (i)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (i)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      LIT_NULL: begin
        unique case (i)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: design/json_stream_validator_core.sv
//------------------------------------------------------------------------------
// json_stream_validator_core
// Streaming strict JSON syntax checker, one byte per transaction.
//------------------------------------------------------------------------------
// Usage:
//   s_axis: tdata[7:0] = data_byte, tuser = cmd (0 document byte, 1 end).
//   m_axis: one result per input transaction, tdata = status[1:0],
//     error_code[6:2], error_offset[38:7], nesting[48:39], zero padded.
//   cfg_we / cfg_wdata write max_nesting; write only while idle.
// Output: each result is registered in the output buffer before it is offered.
// Throughput: one byte per cycle while s_axis_tready is high. The stack pop read is
//   registered, so the top-of-stack bit is kept in a flop beside the memory and
//   refreshed from the memory read on each pop; the parser logic takes one pass
//   per byte, and a second pass in the same cycle for a number ending byte.
// Stall: the result sits in a two-entry output buffer; s_axis_tready drops
//   whenever that buffer is full; it fills while the receiver holds m_axis_tready low.
// Reset: clears parser, counters and sticky error; max_nesting returns to
//   512. The container stack is not cleared; only written entries are used.
//------------------------------------------------------------------------------
module json_stream_validator_core
  import jsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status, error_code, error_offset, nesting
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

  logic [9:0]  max_nesting;
  logic        stack_mem [StackDepth];
  logic        top_bit;      // kind of container at depth_count-1
  logic        below_bit;    // kind at depth_count-2, read from memory
  logic [9:0]  depth_count;
  logic [4:0]  parse_state;
  logic [31:0] byte_offset;
  logic [2:0]  sub_counter;
  logic [7:0]  u8_lo, u8_hi;
  logic [15:0] hex_accum;
  logic [63:0] number_magnitude;
  logic        nf_neg, nf_ovf, nf_float;
  logic [4:0]  sticky_error;
  logic [31:0] sticky_offset;
  logic        string_is_key;
  logic [1:0]  lit_which;

  logic [4:0]  state_next;
  logic [9:0]  depth_next;
  logic [2:0]  sub_next;
  logic [7:0]  u8_lo_next, u8_hi_next;
  logic [15:0] hex_next;
  logic [63:0] mag_next;
  logic        neg_next, ovf_next, float_next;
  logic [4:0]  err_next;
  logic        key_next;
  logic [1:0]  lit_next;
  logic        push, pop, push_bit;

  // output skid buffer
  logic [55:0] ob_data [2];
  logic        ob_rd, ob_wr;
  logic [1:0]  ob_cnt;

  logic in_fire, out_fire;
  assign s_axis_tready = ob_cnt != 2'd2;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ob_cnt != 2'd0;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = ob_data[ob_rd];

  logic [7:0]  c;
  logic [3:0]  dig;
  logic [4:0]  hv;
  logic        hex_ok;
  logic [15:0] hex_acc_new;
  logic [63:0] mag_x10;
  logic [64:0] mag_sum;
  logic [9:0]  limit;
  logic        cont_bit;    // kind of enclosing container after a pop
  logic        num_err;
  logic [4:0]  num_code;

  assign c   = s_axis_tdata;
  assign dig = c[3:0];

  always_comb begin
    hex_ok = 1'b1;
    hv = 5'd0;
    if (is_dig(c)) hv = {1'b0, dig};
    else if (c >= "a" && c <= "f") hv = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") hv = 5'(c - 8'h37);
    else hex_ok = 1'b0;
  end
  assign hex_acc_new = {hex_accum[11:0], hv[3:0]};
  assign mag_x10 = {number_magnitude[60:0], 3'b000} + {number_magnitude[62:0], 1'b0};
  assign mag_sum = {1'b0, mag_x10} + {61'd0, dig};
  assign limit = (max_nesting < 10'(StackDepth)) ? max_nesting : 10'(StackDepth);

  // range check at the end of an integer
  always_comb begin
    num_err = 1'b0;
    num_code = E_NONE;
    if (!nf_float) begin
      if (nf_neg) begin
        if (nf_ovf || number_magnitude > 64'h8000000000000000) begin
          num_err = 1'b1;
          num_code = E_RANGE;
        end
      end else if (nf_ovf) begin
        num_err = 1'b1;
        num_code = E_RANGE;
      end else if (number_magnitude[63]) begin
        num_err = 1'b1;
        num_code = E_RANGE_U;
      end
    end
  end

  always_comb begin
    logic [4:0] st;
    logic       reparse;
    logic       fin;     // value complete: go to the enclosing container
    logic       fin_pop; // value complete by closing a container
    logic [2:0] sc;
    logic [63:0] mag;
    logic       ng;
    logic [9:0] dc;
    state_next = parse_state;
    depth_next = depth_count;
    sub_next   = sub_counter;
    u8_lo_next = u8_lo;
    u8_hi_next = u8_hi;
    hex_next   = hex_accum;
    mag_next   = number_magnitude;
    neg_next   = nf_neg;
    ovf_next   = nf_ovf;
    float_next = nf_float;
    err_next   = E_NONE;
    key_next   = string_is_key;
    lit_next   = lit_which;
    push = 1'b0;
    pop  = 1'b0;
    push_bit = 1'b0;
    fin = 1'b0;
    fin_pop = 1'b0;
    reparse = 1'b0;
    sc = 3'd0;
    mag = 64'd0;
    ng = 1'b0;
    dc = depth_count;
    st = parse_state;
    cont_bit = top_bit;

    // first pass: number states may end and hand the byte to the next state
    if (st == S_NUM_ZERO || st == S_NUM_INT || st == S_NUM_FRAC || st == S_NUM_EXP) begin
      unique case (st)
        S_NUM_ZERO, S_NUM_INT: begin
          if (is_dig(c)) begin
            if (st == S_NUM_ZERO) err_next = E_LZERO;
            else if (!nf_ovf) begin
              if (mag_sum[64] || number_magnitude > 64'h1999999999999999) ovf_next = 1'b1;
              else mag_next = mag_sum[63:0];
            end
          end else if (c == ".") begin
            float_next = 1'b1;
            state_next = S_NUM_DOT;
          end else if (c == "e" || c == "E") begin
            float_next = 1'b1;
            state_next = S_NUM_E;
          end else reparse = 1'b1;
        end
        S_NUM_FRAC: begin
          if (c == "e" || c == "E") state_next = S_NUM_E;
          else if (!is_dig(c)) reparse = 1'b1;
        end
        default: begin
          if (!is_dig(c)) reparse = 1'b1;
        end
      endcase
      if (reparse) begin
        if (num_err) begin
          err_next = num_code;
          reparse = 1'b0;
        end else if (depth_count == 10'd0) st = S_DONE;
        else st = top_bit ? S_OBJ_NEXT : S_ARR_NEXT;
        state_next = st;
      end
    end

    if (!(st == S_NUM_ZERO || st == S_NUM_INT || st == S_NUM_FRAC || st == S_NUM_EXP)) begin
      logic sv; // start a value
      sv = 1'b0;
      unique case (st)
        S_VALUE: sv = !is_ws(c);
        S_ARR_FIRST: begin
          if (c == "]") fin_pop = 1'b1;
          else sv = !is_ws(c);
        end
        S_ARR_ELEM: begin
          if (c == "]") err_next = E_COMMA;
          else sv = !is_ws(c);
        end
        S_OBJ_FIRST, S_OBJ_KEY: begin
          if (!is_ws(c)) begin
            if (c == "}") begin
              if (st == S_OBJ_KEY) err_next = E_COMMA;
              else fin_pop = 1'b1;
            end else if (c == "\"") begin
              key_next = 1'b1;
              state_next = S_STR;
            end else err_next = E_KEY;
          end
        end
        S_COLON: begin
          if (!is_ws(c)) begin
            if (c == ":") state_next = S_VALUE;
            else err_next = E_COLON;
          end
        end
        S_OBJ_NEXT, S_ARR_NEXT: begin
          if (!is_ws(c)) begin
            if (c == ",") state_next = (st == S_OBJ_NEXT) ? S_OBJ_KEY : S_ARR_ELEM;
            else if (c == ((st == S_OBJ_NEXT) ? 8'h7D : 8'h5D)) fin_pop = 1'b1;
            else err_next = E_SEP;
          end
        end
        S_DONE: if (!is_ws(c)) err_next = E_TRAIL;
        S_STR: begin
          if (c == "\"") begin
            if (string_is_key) state_next = S_COLON;
            else fin = 1'b1;
          end else if (c == "\\") state_next = S_ESC;
          else if (c < 8'h20) err_next = E_CTRL;
          else if (c >= 8'h80) begin
            u8_lo_next = 8'h80;
            u8_hi_next = 8'hBF;
            state_next = S_U8_FIRST;
            if (c >= 8'hC2 && c <= 8'hDF) sub_next = 3'd1;
            else if (c >= 8'hE0 && c <= 8'hEF) begin
              sub_next = 3'd2;
              if (c == 8'hE0) u8_lo_next = 8'hA0;
              else if (c == 8'hED) u8_hi_next = 8'h9F;
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
              sub_next = 3'd3;
              if (c == 8'hF0) u8_lo_next = 8'h90;
              else if (c == 8'hF4) u8_hi_next = 8'h8F;
            end else begin
              err_next = E_U8_LEAD;
              state_next = st;
              sub_next = sub_counter;
              u8_lo_next = u8_lo;
              u8_hi_next = u8_hi;
            end
          end
        end
        S_ESC: begin
          if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
              c == "r" || c == "t") state_next = S_STR;
          else if (c == "u") begin
            hex_next = 16'd0;
            sub_next = 3'd0;
            state_next = S_HEX;
          end else err_next = E_ESC;
        end
        S_HEX, S_LOW_HEX: begin
          if (!hex_ok) err_next = E_HEX;
          else begin
            hex_next = hex_acc_new;
            sc = sub_counter + 3'd1;
            sub_next = sc;
            if (sc >= 3'd4) begin
              if (st == S_LOW_HEX) begin
                if (hex_acc_new < 16'hDC00 || hex_acc_new > 16'hDFFF) err_next = E_LOW;
                else state_next = S_STR;
              end else if (hex_acc_new >= 16'hD800 && hex_acc_new <= 16'hDBFF)
                state_next = S_HIGH_BSL;
              else if (hex_acc_new >= 16'hDC00 && hex_acc_new <= 16'hDFFF)
                err_next = E_LONE_LOW;
              else state_next = S_STR;
            end
          end
        end
        S_HIGH_BSL: begin
          if (c == "\\") state_next = S_HIGH_U;
          else err_next = E_HIGH;
        end
        S_HIGH_U: begin
          if (c == "u") begin
            hex_next = 16'd0;
            sub_next = 3'd0;
            state_next = S_LOW_HEX;
          end else err_next = E_HIGH;
        end
        S_U8_FIRST: begin
          if (c < u8_lo || c > u8_hi) err_next = E_U8_SECOND;
          else begin
            sub_next = sub_counter - 3'd1;
            state_next = (sub_counter == 3'd1) ? S_STR : S_U8_REST;
          end
        end
        S_U8_REST: begin
          if (c[7:6] != 2'b10) err_next = E_U8_CONT;
          else begin
            sub_next = sub_counter - 3'd1;
            if (sub_counter == 3'd1) state_next = S_STR;
          end
        end
        S_LIT: begin
          if (sub_counter >= lit_len(lit_which) || c != lit_char(lit_which, sub_counter))
            err_next = E_LIT;
          else begin
            sub_next = sub_counter + 3'd1;
            if (sub_counter + 3'd1 == lit_len(lit_which)) fin = 1'b1;
          end
        end
        S_NUM_SIGN: begin
          if (c == "0") state_next = S_NUM_ZERO;
          else if (is_dig(c)) begin
            mag_next = {60'd0, dig};
            state_next = S_NUM_INT;
          end else err_next = E_MINUS;
        end
        S_NUM_DOT: begin
          if (is_dig(c)) state_next = S_NUM_FRAC;
          else err_next = E_FRAC;
        end
        S_NUM_E: begin
          if (c == "+" || c == "-") state_next = S_NUM_ESIGN;
          else if (is_dig(c)) state_next = S_NUM_EXP;
          else err_next = E_EXP;
        end
        S_NUM_ESIGN: begin
          if (is_dig(c)) state_next = S_NUM_EXP;
          else err_next = E_EXP;
        end
        default: err_next = E_END;
      endcase

      if (sv) begin
        mag = 64'd0;
        ng = 1'b0;
        mag_next = 64'd0;
        neg_next = 1'b0;
        ovf_next = 1'b0;
        float_next = 1'b0;
        sub_next = 3'd1;
        if (c == "{" || c == "[") begin
          if (depth_count >= limit) err_next = E_DEPTH;
          else begin
            push = 1'b1;
            push_bit = (c == "{");
            depth_next = depth_count + 10'd1;
            state_next = (c == "{") ? S_OBJ_FIRST : S_ARR_FIRST;
          end
        end else if (c == "\"") begin
          key_next = 1'b0;
          state_next = S_STR;
        end else if (c == "t") begin
          lit_next = LIT_TRUE;
          state_next = S_LIT;
        end else if (c == "f") begin
          lit_next = LIT_FALSE;
          state_next = S_LIT;
        end else if (c == "n") begin
          lit_next = LIT_NULL;
          state_next = S_LIT;
        end else if (c == "-") begin
          ng = 1'b1;
          neg_next = ng;
          state_next = S_NUM_SIGN;
        end else if (c == "0") state_next = S_NUM_ZERO;
        else if (is_dig(c)) begin
          mag = {60'd0, dig};
          mag_next = mag;
          state_next = S_NUM_INT;
        end else err_next = E_CHAR;
      end
    end

    if (fin_pop) begin
      pop = depth_count != 10'd0;
      dc = pop ? depth_count - 10'd1 : depth_count;
      depth_next = dc;
      cont_bit = below_bit;
      if (dc == 10'd0) state_next = S_DONE;
      else state_next = below_bit ? S_OBJ_NEXT : S_ARR_NEXT;
    end else if (fin) begin
      if (depth_count == 10'd0) state_next = S_DONE;
      else state_next = top_bit ? S_OBJ_NEXT : S_ARR_NEXT;
    end
  end

  // end-of-document verdict
  logic [4:0] end_err;
  always_comb begin
    end_err = E_NONE;
    unique case (parse_state)
      S_DONE: end_err = E_NONE;
      S_NUM_ZERO, S_NUM_INT, S_NUM_FRAC, S_NUM_EXP: begin
        if (num_err) end_err = num_code;
        else if (depth_count != 10'd0) end_err = E_END;
      end
      S_NUM_SIGN: end_err = E_MINUS;
      S_NUM_DOT: end_err = E_FRAC;
      S_NUM_E, S_NUM_ESIGN: end_err = E_EXP;
      S_LIT: end_err = E_LIT;
      S_HIGH_BSL, S_HIGH_U: end_err = E_HIGH;
      S_STR, S_ESC, S_HEX, S_LOW_HEX, S_U8_FIRST, S_U8_REST: end_err = E_END_STR;
      default: end_err = E_END;
    endcase
  end

  logic        active;
  logic [4:0]  res_err;
  logic [31:0] res_off;
  logic [9:0]  res_nest;
  logic [1:0]  res_status;
  assign active = in_fire && sticky_error == E_NONE;

  always_comb begin
    res_err = sticky_error;
    res_off = sticky_offset;
    if (sticky_error == E_NONE) begin
      if (s_axis_tuser && end_err != E_NONE) begin
        res_err = end_err;
        res_off = byte_offset;
      end else if (!s_axis_tuser && err_next != E_NONE) begin
        res_err = err_next;
        res_off = byte_offset;
      end
    end
    if (s_axis_tuser) begin
      res_status = (res_err != E_NONE) ? ST_BAD : ST_OK;
      res_nest = 10'd0;
    end else begin
      res_status = (res_err != E_NONE) ? ST_BAD : ST_BUSY;
      res_nest = (active && err_next == E_NONE) ? depth_next : depth_count;
    end
  end

  // depth after this edge; the memory read for the entry below the new top
  // is registered so below_bit is ready for a pop on the next byte
  logic [9:0] depth_d;
  always_comb begin
    depth_d = depth_count;
    if (rst || (in_fire && s_axis_tuser)) depth_d = 10'd0;
    else if (active && err_next == E_NONE) depth_d = depth_next;
  end

  // stack memory: one write and one registered read per cycle; a push
  // writes the new top while the read fetches the old top, never the same entry
  always_ff @(posedge clk) begin
    if (active && !s_axis_tuser && err_next == E_NONE && push)
      stack_mem[StackAw'(depth_count)] <= push_bit;
    below_bit <= stack_mem[StackAw'(depth_d - 10'd2)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nesting <= 10'd512;
    end else if (cfg_we) begin
      max_nesting <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && s_axis_tuser)) begin
      depth_count <= 10'd0;
      parse_state <= S_VALUE;
      byte_offset <= 32'd0;
      sub_counter <= 3'd0;
      u8_lo <= 8'h80;
      u8_hi <= 8'hBF;
      hex_accum <= 16'd0;
      number_magnitude <= 64'd0;
      nf_neg <= 1'b0;
      nf_ovf <= 1'b0;
      nf_float <= 1'b0;
      sticky_error <= E_NONE;
      sticky_offset <= 32'd0;
      string_is_key <= 1'b0;
      lit_which <= LIT_TRUE;
      top_bit <= 1'b0;
    end else if (in_fire) begin
      byte_offset <= byte_offset + 32'd1;
      if (active) begin
        if (err_next != E_NONE) begin
          sticky_error <= err_next;
          sticky_offset <= byte_offset;
          // state partly updated before a number range error is harmless:
          // the document is dead until end
        end else begin
          parse_state <= state_next;
          depth_count <= depth_next;
          sub_counter <= sub_next;
          u8_lo <= u8_lo_next;
          u8_hi <= u8_hi_next;
          hex_accum <= hex_next;
          number_magnitude <= mag_next;
          nf_neg <= neg_next;
          nf_ovf <= ovf_next;
          nf_float <= float_next;
          string_is_key <= key_next;
          lit_which <= lit_next;
          if (push) top_bit <= push_bit;
          else if (pop) top_bit <= cont_bit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_rd <= 1'b0;
      ob_wr <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (in_fire) ob_wr <= ~ob_wr;
      if (out_fire) ob_rd <= ~ob_rd;
      ob_cnt <= ob_cnt + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) ob_data[ob_wr] <= {7'd0, res_nest, res_off, res_err, res_status};
  end

`ifndef NO_ASSERTIONS
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    depth_count <= 10'(StackDepth))
    else $error("depth above stack size");
  a_sticky_hold: assert property (@(posedge clk) disable iff (rst)
    (sticky_error != E_NONE && !(in_fire && s_axis_tuser)) |=> $stable(sticky_error))
    else $error("sticky error changed");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser) |=> (depth_count == 10'd0 && sticky_error == E_NONE))
    else $error("end did not clear document state");
  a_buf_count: assert property (@(posedge clk) disable iff (rst)
    ob_cnt != 2'd3)
    else $error("output buffer overflow");
`endif

endmodule

FILE: bench/tb_json_stream_validator_core.sv
//------------------------------------------------------------------------------
// tb_json_stream_validator_core
// Self-checking bench for the streaming JSON syntax validator. Documents are
// built at random, mostly from the JSON grammar, and some are then corrupted.
// The documents are fed byte by byte, each followed by an end transaction.
// A behavioral parser in the bench predicts every result transaction.
//------------------------------------------------------------------------------
module tb_json_stream_validator_core;
  import jsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
  } doc_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  code;
    logic [31:0] offset;
    logic [9:0]  nesting;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte[7:0]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // status, error_code, error_offset, nesting
  logic        cfg_we;
  logic [9:0]  cfg_wdata;

  json_stream_validator_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  doc_item_t   pending_bytes[$];
  verdict_t    verdicts_due[$];
  logic [7:0]  doc[$];
  int          queued;
  int          errors;
  bit          idle_on;
  int unsigned cur_limit;

  // ---------------- parser model ----------------
  bit          stk[StackDepth];
  int unsigned depth;
  logic [4:0]  pstate;
  logic [31:0] boff;
  int unsigned sub;
  logic [7:0]  u8_lo, u8_hi;
  logic [15:0] hacc;
  logic [63:0] mag;
  bit          neg, ovf, flt;
  logic [4:0]  err;
  logic [31:0] err_off;
  int unsigned max_nest;
  bit          in_key;
  int unsigned litw;
  string       lits[3] = '{"true", "false", "null"};

  function automatic void clear_doc();
    depth = 0; pstate = S_VALUE; boff = '0; sub = 0; u8_lo = 8'h80; u8_hi = 8'hBF;
    hacc = '0; mag = '0; neg = 0; ovf = 0; flt = 0; err = E_NONE; err_off = '0;
    in_key = 0; litw = 0;
  endfunction

  function automatic void flag(input logic [4:0] e);
    if (err == E_NONE) begin
      err = e;
      err_off = boff;
    end
  endfunction

  function automatic bit ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void value_done();
    if (depth == 0) pstate = S_DONE;
    else pstate = stk[(depth - 1) % StackDepth] ? S_OBJ_NEXT : S_ARR_NEXT;
  endfunction

  function automatic void push_level(input bit obj);
    int unsigned lim;
    lim = max_nest < StackDepth ? max_nest : StackDepth;
    if (depth >= lim) begin
      flag(E_DEPTH);
      return;
    end
    stk[depth % StackDepth] = obj;
    depth++;
    pstate = obj ? S_OBJ_FIRST : S_ARR_FIRST;
  endfunction

  function automatic void pop_level();
    if (depth > 0) depth--;
    value_done();
  endfunction

  function automatic void begin_value(input logic [7:0] c);
    mag = '0; neg = 0; ovf = 0; flt = 0; sub = 1;
    if (c == "{") push_level(1);
    else if (c == "[") push_level(0);
    else if (c == "\"") begin in_key = 0; pstate = S_STR; end
    else if (c == "t") begin litw = 0; pstate = S_LIT; end
    else if (c == "f") begin litw = 1; pstate = S_LIT; end
    else if (c == "n") begin litw = 2; pstate = S_LIT; end
    else if (c == "-") begin neg = 1; pstate = S_NUM_SIGN; end
    else if (c == "0") pstate = S_NUM_ZERO;
    else if (dig(c)) begin mag = 64'(c - "0"); pstate = S_NUM_INT; end
    else flag(E_CHAR);
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - "0");
    if (ovf) return;
    if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) ovf = 1;
    else mag = mag * 10 + d;
  endfunction

  function automatic bit range_ok();
    if (flt) return 1;
    if (neg) begin
      if (ovf || mag > 64'h8000_0000_0000_0000) begin flag(E_RANGE); return 0; end
    end else begin
      if (ovf) begin flag(E_RANGE); return 0; end
      if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin flag(E_RANGE_U); return 0; end
    end
    return 1;
  endfunction

  function automatic bit close_number();
    if (!range_ok()) return 0;
    value_done();
    return 1;
  endfunction

  function automatic int hexval(input logic [7:0] c);
    if (dig(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void str_byte(input logic [7:0] c);
    logic [7:0] lo, hi;
    int unsigned cont;
    lo = 8'h80; hi = 8'hBF;
    if (c == "\"") begin
      if (in_key) pstate = S_COLON; else value_done();
      return;
    end
    if (c == "\\") begin pstate = S_ESC; return; end
    if (c < 8'h20) begin flag(E_CTRL); return; end
    if (c < 8'h80) return;
    if (c >= 8'hC2 && c <= 8'hDF) cont = 1;
    else if (c >= 8'hE0 && c <= 8'hEF) begin
      cont = 2;
      if (c == 8'hE0) lo = 8'hA0; else if (c == 8'hED) hi = 8'h9F;
    end else if (c >= 8'hF0 && c <= 8'hF4) begin
      cont = 3;
      if (c == 8'hF0) lo = 8'h90; else if (c == 8'hF4) hi = 8'h8F;
    end else begin
      flag(E_U8_LEAD);
      return;
    end
    sub = cont; u8_lo = lo; u8_hi = hi;
    pstate = S_U8_FIRST;
  endfunction

  function automatic void hex_byte(input logic [7:0] c);
    int v;
    v = hexval(c);
    if (v < 0) begin flag(E_HEX); return; end
    hacc = {hacc[11:0], 4'(v)};
    sub++;
    if (sub < 4) return;
    if (pstate == S_LOW_HEX) begin
      if (hacc < 16'hDC00 || hacc > 16'hDFFF) flag(E_LOW); else pstate = S_STR;
    end else if (hacc >= 16'hD800 && hacc <= 16'hDBFF) pstate = S_HIGH_BSL;
    else if (hacc >= 16'hDC00 && hacc <= 16'hDFFF) flag(E_LONE_LOW);
    else pstate = S_STR;
  endfunction

  // returns 1 when the byte ended a number and must be parsed again
  function automatic bit parse_byte(input logic [7:0] c);
    case (pstate)
      S_VALUE: if (!ws(c)) begin_value(c);
      S_ARR_FIRST: if (!ws(c)) begin
        if (c == "]") pop_level(); else begin_value(c);
      end
      S_ARR_ELEM: if (!ws(c)) begin
        if (c == "]") flag(E_COMMA); else begin_value(c);
      end
      S_OBJ_FIRST, S_OBJ_KEY: if (!ws(c)) begin
        if (c == "}") begin
          if (pstate == S_OBJ_KEY) flag(E_COMMA); else pop_level();
        end else if (c == "\"") begin
          in_key = 1; pstate = S_STR;
        end else flag(E_KEY);
      end
      S_COLON: if (!ws(c)) begin
        if (c == ":") pstate = S_VALUE; else flag(E_COLON);
      end
      S_OBJ_NEXT, S_ARR_NEXT: if (!ws(c)) begin
        if (c == ",") pstate = (pstate == S_OBJ_NEXT) ? S_OBJ_KEY : S_ARR_ELEM;
        else if (c == ((pstate == S_OBJ_NEXT) ? "}" : "]")) pop_level();
        else flag(E_SEP);
      end
      S_DONE: if (!ws(c)) flag(E_TRAIL);
      S_STR: str_byte(c);
      S_ESC: begin
        if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
            c == "r" || c == "t") pstate = S_STR;
        else if (c == "u") begin hacc = '0; sub = 0; pstate = S_HEX; end
        else flag(E_ESC);
      end
      S_HEX, S_LOW_HEX: hex_byte(c);
      S_HIGH_BSL: if (c == "\\") pstate = S_HIGH_U; else flag(E_HIGH);
      S_HIGH_U: begin
        if (c == "u") begin hacc = '0; sub = 0; pstate = S_LOW_HEX; end
        else flag(E_HIGH);
      end
      S_U8_FIRST: begin
        if (c < u8_lo || c > u8_hi) flag(E_U8_SECOND);
        else begin
          sub--;
          pstate = (sub == 0) ? S_STR : S_U8_REST;
        end
      end
      S_U8_REST: begin
        if (c[7:6] != 2'b10) flag(E_U8_CONT);
        else begin
          sub--;
          if (sub == 0) pstate = S_STR;
        end
      end
      S_LIT: begin
        if (sub >= lits[litw].len() || c != lits[litw][sub]) flag(E_LIT);
        else begin
          sub++;
          if (sub == lits[litw].len()) value_done();
        end
      end
      S_NUM_SIGN: begin
        if (c == "0") pstate = S_NUM_ZERO;
        else if (dig(c)) begin mag = 64'(c - "0"); pstate = S_NUM_INT; end
        else flag(E_MINUS);
      end
      S_NUM_ZERO, S_NUM_INT: begin
        if (dig(c)) begin
          if (pstate == S_NUM_ZERO) flag(E_LZERO); else add_digit(c);
        end else if (c == ".") begin flt = 1; pstate = S_NUM_DOT; end
        else if (c == "e" || c == "E") begin flt = 1; pstate = S_NUM_E; end
        else return close_number();
      end
      S_NUM_DOT: if (dig(c)) pstate = S_NUM_FRAC; else flag(E_FRAC);
      S_NUM_FRAC: if (!dig(c)) begin
        if (c == "e" || c == "E") pstate = S_NUM_E; else return close_number();
      end
      S_NUM_E: begin
        if (c == "+" || c == "-") pstate = S_NUM_ESIGN;
        else if (dig(c)) pstate = S_NUM_EXP;
        else flag(E_EXP);
      end
      S_NUM_ESIGN: if (dig(c)) pstate = S_NUM_EXP; else flag(E_EXP);
      S_NUM_EXP: if (!dig(c)) return close_number();
      default: flag(E_END);
    endcase
    return 0;
  endfunction

  function automatic void close_doc();
    case (pstate)
      S_DONE: ;
      S_NUM_ZERO, S_NUM_INT, S_NUM_FRAC, S_NUM_EXP: begin
        if (range_ok()) begin
          value_done();
          if (pstate != S_DONE) flag(E_END);
        end
      end
      S_NUM_SIGN: flag(E_MINUS);
      S_NUM_DOT: flag(E_FRAC);
      S_NUM_E, S_NUM_ESIGN: flag(E_EXP);
      S_LIT: flag(E_LIT);
      S_HIGH_BSL, S_HIGH_U: flag(E_HIGH);
      S_STR, S_ESC, S_HEX, S_LOW_HEX, S_U8_FIRST, S_U8_REST: flag(E_END_STR);
      default: flag(E_END);
    endcase
  endfunction

  function automatic verdict_t validate(input doc_item_t it);
    verdict_t v;
    if (!it.cmd) begin
      if (err == E_NONE)
        while (parse_byte(it.b) && err == E_NONE) begin end
      boff = boff + 1;
      v.status = (err != E_NONE) ? ST_BAD : ST_BUSY;
      v.nesting = 10'(depth);
    end else begin
      if (err == E_NONE) close_doc();
      v.status = (err != E_NONE) ? ST_BAD : ST_OK;
      v.nesting = '0;
    end
    v.code = err;
    v.offset = err_off;
    if (it.cmd) clear_doc();
    return v;
  endfunction

  // ---------------- document generator ----------------
  function automatic logic [7:0] hexch(input int v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic void put_ch(input logic [7:0] ch);
    doc.insert(doc.size(), ch);
  endfunction

  function automatic void put_str(input string s);
    foreach (s[i]) put_ch(s[i]);
  endfunction

  function automatic void put_u16(input logic [15:0] v);
    put_str("\\u");
    for (int i = 3; i >= 0; i--) put_ch(hexch(v[i*4 +: 4]));
  endfunction

  function automatic void gen_ws();
    logic [7:0] w[4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    if ($urandom_range(0, 3) == 0) put_ch(w[$urandom_range(0, 3)]);
  endfunction

  function automatic void gen_string();
    logic [7:0] esc[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    logic [7:0] c, lo, hi;
    put_ch("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == "\"" || c == "\\") c = "a";
          put_ch(c);
        end
        3: begin put_ch("\\"); put_ch(esc[$urandom_range(0, 7)]); end
        4: put_u16(16'($urandom_range(0, 16'hD7FF)));
        5: begin
          put_u16(16'($urandom_range(16'hD800, 16'hDBFF)));
          put_u16(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        6: put_u16(16'($urandom_range(16'hE000, 16'hFFFF)));
        7: begin
          put_ch(8'($urandom_range(8'hC2, 8'hDF)));
          put_ch(8'($urandom_range(8'h80, 8'hBF)));
        end
        8: begin
          c = 8'($urandom_range(8'hE0, 8'hEF));
          lo = (c == 8'hE0) ? 8'hA0 : 8'h80;
          hi = (c == 8'hED) ? 8'h9F : 8'hBF;
          put_ch(c);
          put_ch($urandom_range(0, 1) ? lo : hi);
          put_ch(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          c = 8'($urandom_range(8'hF0, 8'hF4));
          lo = (c == 8'hF0) ? 8'h90 : 8'h80;
          hi = (c == 8'hF4) ? 8'h8F : 8'hBF;
          put_ch(c);
          put_ch(8'($urandom_range(lo, hi)));
          put_ch(8'($urandom_range(8'h80, 8'hBF)));
          put_ch(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end
    put_ch("\"");
  endfunction

  function automatic void gen_number();
    string big[6] = '{"9223372036854775807", "9223372036854775808",
                      "18446744073709551615", "18446744073709551616",
                      "99999999999999999999", "12345678901234567"};
    int pick;
    pick = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) put_ch("-");
    if (pick == 0) put_ch("0");
    else if (pick == 1) put_str(big[$urandom_range(0, 5)]);
    else begin
      put_ch(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) put_ch(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      put_ch(".");
      repeat ($urandom_range(1, 3)) put_ch(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      put_ch($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: put_ch("+");
        1: put_ch("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) put_ch(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void gen_value(input int lvl, input int maxd);
    int n;
    gen_ws();
    case ($urandom_range(0, (lvl < maxd) ? 7 : 4))
      0, 1: gen_string();
      2: gen_number();
      3: put_str(lits[$urandom_range(0, 2)]);
      4: gen_number();
      5, 6: begin
        put_ch("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_ch(",");
          gen_value(lvl + 1, maxd);
        end
        gen_ws();
        put_ch("]");
      end
      default: begin
        put_ch("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_ch(",");
          gen_ws();
          gen_string();
          gen_ws();
          put_ch(":");
          gen_value(lvl + 1, maxd);
        end
        gen_ws();
        put_ch("}");
      end
    endcase
    gen_ws();
  endfunction

  function automatic void emit_doc();
    foreach (doc[i])
      pending_bytes.insert(pending_bytes.size(), doc_item_t'{1'b0, doc[i]});
    // end transaction carries a random byte that must be ignored
    pending_bytes.insert(pending_bytes.size(),
                         doc_item_t'{1'b1, 8'($urandom_range(0, 255))});
    queued += doc.size() + 1;
    doc.delete();
  endfunction

  function automatic void random_doc();
    logic [7:0] tweak[10] = '{",", "]", "}", ":", "\"", "\\", 8'h00, 8'hFF, "0", "x"};
    int pos;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) put_ch(8'($urandom_range(0, 255)));
    end else begin
      gen_value(0, (cur_limit < 6) ? cur_limit + 1 : 4);
      case ($urandom_range(0, 5))
        0: begin
          pos = $urandom_range(0, doc.size() - 1);
          doc[pos] = $urandom_range(0, 1) ? tweak[$urandom_range(0, 9)]
                                          : 8'($urandom_range(0, 255));
        end
        1: begin
          pos = $urandom_range(0, doc.size() - 1);
          while (doc.size() > pos) void'(doc.pop_back());
        end
        2: begin
          pos = $urandom_range(0, doc.size());
          doc.insert(pos, tweak[$urandom_range(0, 9)]);
        end
        default: ;
      endcase
    end
    emit_doc();
  endfunction

  // ---------------- clock, reset, sequencing ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 16) : 0;
  endfunction

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limit(input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 10'(v);
    max_nest = v;
    cur_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned limits[6];
    int target;
    rst = 1; cfg_we = 0; cfg_wdata = '0;
    errors = 0; queued = 0; idle_on = 0;
    max_nest = 512; cur_limit = 512;
    foreach (stk[i]) stk[i] = 0;
    clear_doc();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_limit(512);

    // directed: a valid document, error cases at end and mid-document, a range edge
    put_str("{\"k\":[1,-0.5e+3,true,null]}"); emit_doc();
    put_str("-"); emit_doc();
    put_str("01"); emit_doc();
    put_str("fals"); emit_doc();
    put_str("\"\\ud800"); emit_doc();
    put_str("[1,]"); emit_doc();
    put_str("-9223372036854775808"); emit_doc();
    drain();

    limits = '{1, 2, 5, 512, 0, 3};
    limits[5] = $urandom_range(1, 512);
    foreach (limits[p]) begin
      set_limit(limits[p]);
      idle_on = (p % 2 == 0);
      if (limits[p] == 512) begin
        // one past the top of the stack
        repeat (513) put_ch("[");
        emit_doc();
      end
      target = queued + 75;
      while (queued < target) random_doc();
      drain();
    end

    drain();
    if (errors == 0) $display("tb_json_stream_validator_core passed");
    else $display("tb_json_stream_validator_core failed");
    $finish;
  end

  // ---------------- driver ----------------
  int tx_wait;
  always @(posedge clk) begin
    bit vld;
    doc_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      tx_wait = 0;
    end else begin
      vld = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.insert(verdicts_due.size(),
                            validate(doc_item_t'{s_axis_tuser, s_axis_tdata}));
        vld = 0;
        tx_wait = draw_gap();
      end
      if (!vld) begin
        if (tx_wait > 0) tx_wait--;
        else if (pending_bytes.size() > 0) begin
          it = pending_bytes.pop_front();
          s_axis_tdata <= it.b;
          s_axis_tuser <= it.cmd;
          vld = 1;
        end
      end
      s_axis_tvalid <= vld;
    end
  end

  // ---------------- receiver and checker ----------------
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  int rx_wait, rx_count, hold;
  bit hold_done;
  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0; rx_count = 0; hold = 0; hold_done = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_count++;
        if (verdicts_due.size() == 0) report("unexpected transaction", 0, 0);
        else begin
          w = verdicts_due.pop_front();
          if (m_axis_tdata[1:0] != w.status) report("status", m_axis_tdata[1:0], w.status);
          if (m_axis_tdata[6:2] != w.code) report("error_code", m_axis_tdata[6:2], w.code);
          if (m_axis_tdata[38:7] != w.offset)
            report("error_offset", m_axis_tdata[38:7], w.offset);
          if (m_axis_tdata[48:39] != w.nesting)
            report("nesting", m_axis_tdata[48:39], w.nesting);
        end
        rx_wait = draw_gap();
      end else if (rx_wait > 0) rx_wait--;
      // one long hold-off so the output buffer fills and the input stalls
      if (hold > 0) hold--;
      else if (!hold_done && rx_count >= 100) begin
        hold = 300;
        hold_done = 1;
      end
      m_axis_tready <= (hold == 0 && rx_wait == 0);
    end
  end

  // ---------------- watchdog ----------------
  int quiet;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else begin
      quiet++;
      if (quiet >= 5000) begin
        $display("tb_json_stream_validator_core failed");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
design/jsv_pkg.sv
design/json_stream_validator_core.sv
bench/tb_json_stream_validator_core.sv
